[rtl/dct2d_pkg.sv]
// Shared types, widths and the DCT-II basis generator for the 2-D block transform.
// No dependencies; every other file imports this package.
package dct2d_pkg;

	localparam int DCT2D_BLOCK_SIZE = 8;
	localparam int DCT2D_MAX_BLOCK  = 8;

	localparam int DCT2D_PIXEL_W = 8;
	localparam int DCT2D_COEF_W  = 16;
	localparam int DCT2D_THR_W   = 11;
	localparam int DCT2D_BASIS_W = 16;  // signed Q1.14
	localparam int DCT2D_ROW_W   = 24;  // signed Q11.12
	localparam int DCT2D_PROD_W  = DCT2D_BASIS_W + DCT2D_ROW_W;
	localparam int DCT2D_ACC_W   = DCT2D_PROD_W + $clog2(DCT2D_MAX_BLOCK);
	localparam int DCT2D_TAB_W   = DCT2D_MAX_BLOCK * DCT2D_MAX_BLOCK * DCT2D_BASIS_W;

	localparam longint DCT2D_PI_Q30  = 64'sd3373259426;
	localparam longint DCT2D_ONE_Q30 = 64'sd1073741824;
	localparam longint TaylorDiv [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

	// Control word that travels with each product through the MAC pipeline
	typedef struct packed {
		logic vld;
		logic col;    // column pass (else row pass)
		logic first;  // first term of a dot product
		logic last;   // last term of a dot product
	} mac_ctl_t;

	function automatic longint unsigned dct2d_div_n(input longint unsigned x, input int n);
		longint unsigned q;
		case (n)
			2: q = x / 2;
			3: q = x / 3;
			4: q = x / 4;
			5: q = x / 5;
			6: q = x / 6;
			7: q = x / 7;
			8: q = x / 8;
			default: q = x;
		endcase
		return q;
	endfunction

	function automatic longint unsigned dct2d_isqrt(input longint unsigned v);
		longint unsigned n;
		longint unsigned r;
		longint unsigned b;
		n = v;
		r = 0;
		b = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (b > n)
				b = b >> 2;
		end
		for (int s = 0; s < 32; s++) begin
			if (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// cos(pi*r/(2n)) in Q30, Taylor series, clamped at zero
	function automatic longint dct2d_cos_q30(input longint r, input int n);
		longint x;
		longint x2;
		longint sum;
		longint term;
		x    = longint'(dct2d_div_n(longint'(DCT2D_PI_Q30 * r), n) >> 1);
		x2   = (x * x) >>> 30;
		sum  = DCT2D_ONE_Q30;
		term = DCT2D_ONE_Q30;
		for (int j = 0; j < 8; j++) begin
			term = ((term * x2) >>> 30) / TaylorDiv[j];
			if (j % 2 == 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return (sum < 0) ? 64'sd0 : sum;
	endfunction

	// Packed basis table, entry k*n+i at bits [(k*n+i)*16 +: 16]
	function automatic logic [DCT2D_TAB_W-1:0] dct2d_basis_table(input int n);
		logic [DCT2D_TAB_W-1:0] tab;
		longint unsigned s0;
		longint unsigned sk;
		longint unsigned mag;
		longint m;
		longint r;
		logic neg;
		tab = '0;
		s0 = dct2d_isqrt(dct2d_div_n(64'd1 << 60, n));
		sk = dct2d_isqrt(dct2d_div_n(64'd1 << 61, n));
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++) begin
				m = longint'(k * (2 * i + 1));
				for (int s = 0; s < 4; s++) begin
					if (m >= 4 * n)
						m = m - 4 * n;
				end
				if (m <= n) begin
					r = m;
					neg = 1'b0;
				end else if (m <= 2 * n) begin
					r = 2 * n - m;
					neg = 1'b1;
				end else if (m <= 3 * n) begin
					r = m - 2 * n;
					neg = 1'b1;
				end else begin
					r = 4 * n - m;
					neg = 1'b0;
				end
				mag = ((k == 0 ? s0 : sk) * longint'(dct2d_cos_q30(r, n)) + (64'd1 << 45)) >> 46;
				tab[(k * n + i) * DCT2D_BASIS_W +: DCT2D_BASIS_W] =
					neg ? DCT2D_BASIS_W'(-mag) : DCT2D_BASIS_W'(mag);
			end
		end
		return tab;
	endfunction

endpackage

[rtl/dct2d_if.sv]
// Valid/ready channel interfaces of the 2-D block transform: pixels in,
// coefficients out, threshold register write. Depends on dct2d_pkg.
interface dct2d_pix_if import dct2d_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [DCT2D_PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface dct2d_coef_if import dct2d_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [DCT2D_COEF_W-1:0] coefficient;
	logic                           last_coefficient;

	modport source (output valid, output coefficient, output last_coefficient, input ready);
	modport sink (input valid, input coefficient, input last_coefficient, output ready);
endinterface

interface dct2d_cfg_if import dct2d_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [DCT2D_THR_W-1:0] zero_threshold;

	modport source (output valid, output zero_threshold, input ready);
	modport sink (input valid, input zero_threshold, output ready);
endinterface

[rtl/dct_2d_block_transform_unit.sv]
// Top level of the orthonormal 2-D DCT-II block transform unit.
// Depends on dct2d_pkg, the channel interfaces in dct2d_if and dct2d_seq.
//
// The unit takes the BLOCK_SIZE x BLOCK_SIZE pixels of one block in row-major
// order, one item per cycle, and then computes C = B * X * B^T with a single
// shared 16 x 24 bit multiply-accumulate unit: first the row pass
// T = X * B^T into an internal store (Q11.12, rounded half up), then the column
// pass C = B * T. Coefficients leave in row-major order as signed Q11.4,
// rounded half up, saturated to 16 bits, and forced to zero where their
// magnitude is below zero_threshold * 16; last_coefficient marks the final one.
// The multiplier takes one term per cycle while the output does not stall; each
// block is loaded, then each pass issues its terms and drains the pipeline
// before the next pass or the next block begins.
// The pixel channel is not ready from the last pixel of a block until the
// sequencer returns to its load state after the column pass has drained; a
// consumer that stalls holds the whole multiply pipeline. The threshold register
// may be written at any time the unit is idle and is always ready.
module dct_2d_block_transform_unit import dct2d_pkg::*; #(
	parameter int BLOCK_SIZE = DCT2D_BLOCK_SIZE
) (
	input logic         clk,
	input logic         arst_n,
	dct2d_pix_if.sink   samples,
	dct2d_coef_if.source coefficients,
	dct2d_cfg_if.sink   cfg
);

	localparam int DEPTH = BLOCK_SIZE * BLOCK_SIZE;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(BLOCK_SIZE);
	localparam int C_W   = DCT2D_ACC_W - 22;

	localparam logic [DCT2D_TAB_W-1:0] BASIS = dct2d_basis_table(BLOCK_SIZE);

	localparam logic signed [DCT2D_ACC_W-1:0]  ROW_HALF = DCT2D_ACC_W'(2);
	localparam logic signed [DCT2D_ACC_W-1:0]  COL_HALF = DCT2D_ACC_W'(64'd1 << 21);
	localparam logic signed [C_W-1:0]          C_MAX    = C_W'(32767);
	localparam logic signed [C_W-1:0]          C_MIN    = C_W'(-32768);
	localparam logic signed [DCT2D_COEF_W-1:0] COEF_MAX = DCT2D_COEF_W'(32767);
	localparam logic signed [DCT2D_COEF_W-1:0] COEF_MIN = DCT2D_COEF_W'(-32768);

	function automatic logic [IDX_W-1:0] idx_of(input logic [CNT_W-1:0] hi,
		input logic [CNT_W-1:0] lo);
		return IDX_W'(hi) * IDX_W'(BLOCK_SIZE) + IDX_W'(lo);
	endfunction

	// ---------------------------------------------------------------- control
	logic                   adv;        // pipeline moves on
	logic                   pipe_busy;
	logic                   seq_idle;
	logic                   pix_acc;
	logic                   blk_start;
	logic [IDX_W-1:0]       pix_cnt_q;
	logic [DCT2D_THR_W-1:0] thr_q;

	mac_ctl_t         iss_ctl, ctl_s1, ctl_s2, ctl_s3;
	logic [CNT_W-1:0] iss_a, iss_b, iss_i;
	logic [IDX_W-1:0] dest_s1, dest_s2, dest_s3;

	// ---------------------------------------------------------------- datapath
	logic [DCT2D_PIXEL_W-1:0]        pix_mem [DEPTH];
	logic signed [DCT2D_ROW_W-1:0]   row_mem [DEPTH];
	logic [IDX_W-1:0]                paddr, raddr, bidx, dest;
	logic [DCT2D_PIXEL_W-1:0]        pix_rd_s1;
	logic signed [DCT2D_ROW_W-1:0]   row_rd_s1;
	logic signed [DCT2D_BASIS_W-1:0] basis_s1;
	logic signed [DCT2D_ROW_W-1:0]   opnd;
	logic signed [DCT2D_PROD_W-1:0]  prod_s2;
	logic signed [DCT2D_ACC_W-1:0]   acc_q;
	logic signed [DCT2D_ACC_W-1:0]   row_sum, col_sum;
	logic signed [DCT2D_ROW_W-1:0]   row_val;
	logic signed [C_W-1:0]           c_w;
	logic signed [DCT2D_COEF_W-1:0]  coef_sat, coef_thr;
	logic [DCT2D_COEF_W:0]           coef_ext, coef_mag, thr_cmp;
	logic                            row_wr, col_done;

	logic                           out_vld_q;
	logic signed [DCT2D_COEF_W-1:0] out_coef_q;
	logic                           out_last_q;

	// Hold every stage while a finished coefficient waits and the sink stalls
	assign adv       = !(out_vld_q && !coefficients.ready);
	assign pipe_busy = ctl_s1.vld || ctl_s2.vld || ctl_s3.vld;

	assign samples.ready = seq_idle;
	assign pix_acc       = samples.valid && seq_idle;
	assign blk_start     = pix_acc && (pix_cnt_q == IDX_W'(DEPTH - 1));

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
			thr_q     <= '0;
		end else begin
			if (pix_acc)
				pix_cnt_q <= blk_start ? '0 : pix_cnt_q + 1'b1;
			if (cfg.valid)
				thr_q <= cfg.zero_threshold;
		end
	end

	dct2d_seq #(
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (blk_start),
		.adv      (adv),
		.pipe_busy(pipe_busy),
		.idle     (seq_idle),
		.iss_ctl  (iss_ctl),
		.iss_a    (iss_a),
		.iss_b    (iss_b),
		.iss_i    (iss_i)
	);

	// Row pass: T[a][b] = sum_i X[a][i] * B[b][i]
	// Column pass: C[a][b] = sum_i B[a][i] * T[i][b]
	assign paddr = idx_of(iss_a, iss_i);
	assign raddr = idx_of(iss_i, iss_b);
	assign bidx  = idx_of(iss_ctl.col ? iss_a : iss_b, iss_i);
	assign dest  = idx_of(iss_a, iss_b);

	always_ff @(posedge clk) begin
		if (pix_acc)
			pix_mem[pix_cnt_q] <= samples.pixel;
		if (adv)
			pix_rd_s1 <= pix_mem[paddr];
	end

	always_ff @(posedge clk) begin
		if (adv && row_wr)
			row_mem[dest_s3] <= row_val;
		if (adv)
			row_rd_s1 <= row_mem[raddr];
	end

	// Pipeline control: reset clears the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= iss_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Zero-extend pixels onto the shared multiplier's wide port
	assign opnd = ctl_s1.col ? row_rd_s1
		: $signed({{(DCT2D_ROW_W - DCT2D_PIXEL_W){1'b0}}, pix_rd_s1});

	always_ff @(posedge clk) begin
		if (adv) begin
			basis_s1 <= $signed(BASIS[int'(bidx) * DCT2D_BASIS_W +: DCT2D_BASIS_W]);
			dest_s1  <= dest;
			prod_s2  <= basis_s1 * opnd;
			dest_s2  <= dest_s1;
			dest_s3  <= dest_s2;
			if (ctl_s2.vld)
				acc_q <= (ctl_s2.first ? '0 : acc_q) + DCT2D_ACC_W'(prod_s2);
		end
	end

	// Rounding, saturation and threshold behind the accumulator
	assign row_wr   = ctl_s3.vld && !ctl_s3.col && ctl_s3.last;
	assign col_done = ctl_s3.vld && ctl_s3.col && ctl_s3.last;

	assign row_sum = acc_q + ROW_HALF;
	assign row_val = row_sum[DCT2D_ROW_W+1:2];

	assign col_sum = acc_q + COL_HALF;
	assign c_w     = col_sum[DCT2D_ACC_W-1:22];

	always_comb begin
		if (c_w > C_MAX)
			coef_sat = COEF_MAX;
		else if (c_w < C_MIN)
			coef_sat = COEF_MIN;
		else
			coef_sat = c_w[DCT2D_COEF_W-1:0];
	end

	assign coef_ext = {coef_sat[DCT2D_COEF_W-1], coef_sat};
	assign coef_mag = coef_sat[DCT2D_COEF_W-1] ? ((DCT2D_COEF_W + 1)'(0) - coef_ext) : coef_ext;
	assign thr_cmp  = {2'b00, thr_q, 4'b0000};
	assign coef_thr = (coef_mag < thr_cmp) ? '0 : coef_sat;

	// Output register: load only when the slot is free or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (adv && col_done)
				out_vld_q <= 1'b1;
			else if (coefficients.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && col_done) begin
			out_coef_q <= coef_thr;
			out_last_q <= (dest_s3 == IDX_W'(DEPTH - 1));
		end
	end

	assign coefficients.valid            = out_vld_q;
	assign coefficients.coefficient      = out_coef_q;
	assign coefficients.last_coefficient = out_last_q;

	// ---------------------------------------------------------------- checks
	// Drain keeps the row and column passes apart in the pipeline
	a_pass_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld && ctl_s3.vld |-> ctl_s1.col == ctl_s3.col)
		else $error("row and column pass terms mixed in the MAC pipeline");

	// A finished column product always reaches the output register
	a_coef_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv && col_done |=> coefficients.valid)
		else $error("finished coefficient not presented");

	// Nothing follows the final coefficient of a block straight away
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		coefficients.valid && coefficients.ready && coefficients.last_coefficient
		|=> !coefficients.valid)
		else $error("coefficient emitted right after the last of a block");

	// Pixels are taken only with the MAC pipeline empty
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> !pipe_busy)
		else $error("pixel channel ready while the transform is running");

endmodule

[rtl/dct2d_seq.sv]
// Sequencer of the shared multiply-accumulate unit: walks the row pass,
// then the column pass, issuing one term per cycle while adv is high. Depends on dct2d_pkg.
module dct2d_seq import dct2d_pkg::*; #(
	parameter int BLOCK_SIZE = DCT2D_BLOCK_SIZE,
	localparam int CNT_W     = $clog2(BLOCK_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             adv,
	input  logic             pipe_busy,
	output logic             idle,
	output mac_ctl_t         iss_ctl,
	output logic [CNT_W-1:0] iss_a,
	output logic [CNT_W-1:0] iss_b,
	output logic [CNT_W-1:0] iss_i
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_ROW,
		S_ROW_DRAIN,
		S_COL,
		S_COL_DRAIN
	} state_t;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BLOCK_SIZE - 1);

	state_t           state_q;
	logic [CNT_W-1:0] a_q, b_q, i_q;
	mac_ctl_t         ctl_q;
	logic [CNT_W-1:0] iss_a_q, iss_b_q, iss_i_q;

	assign idle    = (state_q == S_LOAD);
	assign iss_ctl = ctl_q;
	assign iss_a   = iss_a_q;
	assign iss_b   = iss_b_q;
	assign iss_i   = iss_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			a_q     <= '0;
			b_q     <= '0;
			i_q     <= '0;
			ctl_q   <= '0;
			iss_a_q <= '0;
			iss_b_q <= '0;
			iss_i_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (start) begin
						state_q <= S_ROW;
						a_q     <= '0;
						b_q     <= '0;
						i_q     <= '0;
					end
				end
				S_ROW, S_COL: begin
					if (adv) begin
						ctl_q   <= '{vld: 1'b1, col: (state_q == S_COL),
							first: (i_q == '0), last: (i_q == CNT_MAX)};
						iss_a_q <= a_q;
						iss_b_q <= b_q;
						iss_i_q <= i_q;
						// advance term, then output column, then output row
						if (i_q == CNT_MAX) begin
							i_q <= '0;
							if (b_q == CNT_MAX) begin
								b_q <= '0;
								if (a_q == CNT_MAX) begin
									a_q     <= '0;
									state_q <= (state_q == S_ROW) ? S_ROW_DRAIN : S_COL_DRAIN;
								end else begin
									a_q <= a_q + 1'b1;
								end
							end else begin
								b_q <= b_q + 1'b1;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				S_ROW_DRAIN, S_COL_DRAIN: begin
					if (adv)
						ctl_q <= '0;
					if (!ctl_q.vld && !pipe_busy)
						state_q <= (state_q == S_ROW_DRAIN) ? S_COL : S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
